// ===== sv/psrl_pkg.sv =====
// Package for the per-source request rate limiter: table geometry, entry layout,
// window constants and register map. No dependencies.
package psrl_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int FILL_W        = ADDR_W + 1;

    localparam int PADDR_W = 3;

    localparam logic [31:0] MINUTE_WINDOW = 32'd60;
    localparam logic [31:0] HOUR_WINDOW   = 32'd3600;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    localparam logic [15:0] MINUTE_LIMIT_RST = 16'd60;
    localparam logic [15:0] HOUR_LIMIT_RST   = 16'd1000;

    // register index, taken from paddr[2]
    localparam logic REG_MINUTE_LIMIT = 1'b0;
    localparam logic REG_HOUR_LIMIT   = 1'b1;

    typedef struct packed {
        logic [31:0] source;
        logic [31:0] last_time;
        logic [15:0] minute_count;
        logic [15:0] hour_count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_CALC = 5'b00100,
        ST_UPD  = 5'b01000,
        ST_MISS = 5'b10000
    } state_t;

    function automatic logic [15:0] sat_inc(input logic [15:0] c);
        return (c == COUNT_MAX) ? COUNT_MAX : c + 16'd1;
    endfunction

endpackage

// ===== sv/psrl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module psrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/per_source_request_rate_limiter_top.sv =====
// Top level of the per-source request rate limiter: APB registers, sequencer,
// shared compare unit over the source table. Depends on psrl_pkg and psrl_ram.
//
// Usage: each s_ beat is one request (source address, time in seconds). Each
// request gives exactly one m_ beat (blocked, next allowed time, table full).
// The source table sits in one RAM read an entry per cycle; a single 32-bit
// comparator checks one stored source per cycle against the request. Entries
// fill from index 0 upward and are never evicted, so a fill count marks the
// live part of the table.
// The time from s_ beat to m_valid is set by the one-entry-per-cycle scan: it grows
// with the index of a stored source, and for a new source with the number of
// sources stored. One request is in flight at a time and s_ready is high only
// while idle, so a new request is taken only once the last result is registered.
// The result waits in an output register; if the receiver stalls, the
// sequencer holds before its final step until the register frees up.
// Reset (aresetn low, synchronous) empties the table, sets the minute limit
// to 60 and the hour limit to 1000, and drops m_valid. No clearing pass.
// Registers: 0x0 minute_limit, 0x4 hour_limit (16 bits each).
module per_source_request_rate_limiter_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psrl_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [31:0]                   s_source_address,
    input  logic [31:0]                   s_now_seconds,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_blocked,
    output logic [31:0]                   m_next_allowed_at,
    output logic                          m_table_full
);
    import psrl_pkg::*;

    state_t state_reg, state_next;

    logic [15:0] minute_limit_reg, hour_limit_reg;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] scan_reg, scan_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [ADDR_W-1:0] chk_idx_reg, chk_idx_next;
    logic [ADDR_W-1:0] hit_idx_reg, hit_idx_next;

    logic [31:0] src_reg, src_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] last_reg, last_next;
    logic [15:0] mc_reg, mc_next;
    logic [15:0] hc_reg, hc_next;
    logic [31:0] gap_reg, gap_next;

    logic        m_valid_reg, m_valid_next;
    logic        blocked_reg, blocked_next;
    logic [31:0] next_at_reg, next_at_next;
    logic        full_reg, full_next;

    logic              ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
    entry_t            ram_wr_data, ram_rd_data;

    logic        cfg_wr, hit, out_free;
    logic [15:0] mc_upd, hc_upd;

    psrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_HOUR_LIMIT) ? {16'd0, hour_limit_reg}
                                                 : {16'd0, minute_limit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            minute_limit_reg <= MINUTE_LIMIT_RST;
            hour_limit_reg   <= HOUR_LIMIT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MINUTE_LIMIT) begin
                minute_limit_reg <= pwdata[15:0];
            end else begin
                hour_limit_reg <= pwdata[15:0];
            end
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign hit      = chk_valid_reg && (ram_rd_data.source == src_reg);

    assign mc_upd = sat_inc((gap_reg >= MINUTE_WINDOW) ? 16'd0 : mc_reg);
    assign hc_upd = sat_inc((gap_reg >= HOUR_WINDOW) ? 16'd0 : hc_reg);

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        scan_next      = scan_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        hit_idx_next   = hit_idx_reg;
        src_next       = src_reg;
        now_next       = now_reg;
        last_next      = last_reg;
        mc_next        = mc_reg;
        hc_next        = hc_reg;
        gap_next       = gap_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        blocked_next   = blocked_reg;
        next_at_next   = next_at_reg;
        full_next      = full_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = scan_reg[ADDR_W-1:0];
        ram_wr_en      = 1'b0;
        ram_wr_addr    = hit_idx_reg;
        ram_wr_data    = '{source: src_reg, last_time: now_reg,
                           minute_count: mc_upd, hour_count: hc_upd};

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    src_next   = s_source_address;
                    now_next   = s_now_seconds;
                    scan_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    hit_idx_next = chk_idx_reg;
                    last_next    = ram_rd_data.last_time;
                    mc_next      = ram_rd_data.minute_count;
                    hc_next      = ram_rd_data.hour_count;
                    state_next   = ST_CALC;
                end else if (scan_reg < fill_reg) begin
                    ram_rd_en      = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_reg[ADDR_W-1:0];
                    scan_next      = scan_reg + 1'b1;
                end else if (!chk_valid_reg) begin
                    state_next = ST_MISS;
                end
            end
            ST_CALC: begin
                gap_next   = now_reg - last_reg;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (out_free) begin
                    ram_wr_en    = 1'b1;
                    m_valid_next = 1'b1;
                    full_next    = 1'b0;
                    if (mc_upd >= minute_limit_reg) begin
                        blocked_next = 1'b1;
                        next_at_next = last_reg + MINUTE_WINDOW;
                    end else if (hc_upd >= hour_limit_reg) begin
                        blocked_next = 1'b1;
                        next_at_next = last_reg + HOUR_WINDOW;
                    end else begin
                        blocked_next = 1'b0;
                        next_at_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_MISS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    blocked_next = 1'b0;
                    next_at_next = '0;
                    if (fill_reg < FILL_W'(TABLE_ENTRIES)) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = fill_reg[ADDR_W-1:0];
                        ram_wr_data = '{source: src_reg, last_time: now_reg,
                                        minute_count: 16'd1, hour_count: 16'd1};
                        fill_next   = fill_reg + 1'b1;
                        full_next   = 1'b0;
                    end else begin
                        full_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg    <= scan_next;
        chk_idx_reg <= chk_idx_next;
        hit_idx_reg <= hit_idx_next;
        src_reg     <= src_next;
        now_reg     <= now_next;
        last_reg    <= last_next;
        mc_reg      <= mc_next;
        hc_reg      <= hc_next;
        gap_reg     <= gap_next;
        blocked_reg <= blocked_next;
        next_at_reg <= next_at_next;
        full_reg    <= full_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_blocked         = blocked_reg;
    assign m_next_allowed_at = next_at_reg;
    assign m_table_full      = full_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_SCAN)
        else $error("accepted beat did not start a scan");

    a_hit_live: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UPD |-> {1'b0, hit_idx_reg} < fill_reg)
        else $error("update of an entry outside the live table");

    a_pass_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !blocked_reg |-> next_at_reg == 32'd0)
        else $error("passed beat carries a next allowed time");

    a_full_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && full_reg |-> !blocked_reg && fill_reg == FILL_W'(TABLE_ENTRIES))
        else $error("table full flagged on a non-full table or blocked beat");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for per_source_request_rate_limiter_top: directed reset-limit, window, limit and
// table-full tests, then random traffic, all checked against a bench copy of the source table.
// Depends on psrl_pkg and per_source_request_rate_limiter_top.
module tb_top;
    import psrl_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_BEATS   = 300;
    localparam int MAX_REPORTS   = 100;

    typedef struct packed {
        logic        blocked;
        logic [31:0] next_allowed_at;
        logic        table_full;
    } verdict_t;

    typedef enum logic [1:0] { RDY_ALWAYS, RDY_RANDOM, RDY_SPARSE } ready_mode_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_valid;
    logic                 s_ready;
    logic [31:0]          s_source_address;
    logic [31:0]          s_now_seconds;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_blocked;
    logic [31:0]          m_next_allowed_at;
    logic                 m_table_full;

    per_source_request_rate_limiter_top u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_source_address  (s_source_address),
        .s_now_seconds     (s_now_seconds),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_blocked         (m_blocked),
        .m_next_allowed_at (m_next_allowed_at),
        .m_table_full      (m_table_full)
    );

    // bench copy of the source table and limits
    logic        slot_used    [TABLE_ENTRIES];
    logic [31:0] slot_source  [TABLE_ENTRIES];
    logic [31:0] slot_last    [TABLE_ENTRIES];
    logic [15:0] slot_minutes [TABLE_ENTRIES];
    logic [15:0] slot_hours   [TABLE_ENTRIES];
    int          stored_sources = 0;
    logic [15:0] minute_lim     = MINUTE_LIMIT_RST;
    logic [15:0] hour_lim       = HOUR_LIMIT_RST;

    verdict_t    pending_verdicts[$];
    int          error_count = 0;
    bit          fast_mode   = 1'b0;
    int          burst_left  = 0;

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic void report_mismatch(input string field, input logic [31:0] want,
                                            input logic [31:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%08h actual 0x%08h", $time, field, want, got);
    endfunction

    function automatic verdict_t predict_verdict(input logic [31:0] src, input logic [31:0] now);
        int          hit;
        int          free_slot;
        logic [31:0] gap;
        logic [15:0] mc;
        logic [15:0] hc;
        verdict_t    v;
        v         = '0;
        hit       = -1;
        free_slot = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_used[i]) begin
                if (hit < 0 && slot_source[i] == src) hit = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (hit < 0) begin
            if (free_slot >= 0) begin
                slot_used[free_slot]    = 1'b1;
                slot_source[free_slot]  = src;
                slot_last[free_slot]    = now;
                slot_minutes[free_slot] = 16'd1;
                slot_hours[free_slot]   = 16'd1;
                stored_sources++;
            end else begin
                v.table_full = 1'b1;
            end
            return v;
        end
        gap = now - slot_last[hit];
        mc  = (gap >= MINUTE_WINDOW) ? 16'd0 : slot_minutes[hit];
        hc  = (gap >= HOUR_WINDOW) ? 16'd0 : slot_hours[hit];
        if (mc != COUNT_MAX) mc = mc + 16'd1;
        if (hc != COUNT_MAX) hc = hc + 16'd1;
        slot_last[hit]    = now;
        slot_minutes[hit] = mc;
        slot_hours[hit]   = hc;
        if (mc >= minute_lim) begin
            v.blocked         = 1'b1;
            v.next_allowed_at = now + MINUTE_WINDOW - gap;
        end else if (hc >= hour_lim) begin
            v.blocked         = 1'b1;
            v.next_allowed_at = now + HOUR_WINDOW - gap;
        end
        return v;
    endfunction

    function automatic bit source_stored(input logic [31:0] src);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot_used[i] && slot_source[i] == src) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [31:0] pick_gap();
        case ($urandom_range(0, 11))
            0:       return MINUTE_WINDOW - 32'd1;
            1:       return MINUTE_WINDOW;
            2:       return HOUR_WINDOW - 32'd1;
            3:       return HOUR_WINDOW;
            4:       return $urandom_range(60, 3599);
            5:       return $urandom;
            default: return $urandom_range(0, 59);
        endcase
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return COUNT_MAX;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(2, 12));
        endcase
    endfunction

    task automatic send_request(input logic [31:0] src, input logic [31:0] now);
        int idle_cycles;
        if (!fast_mode && burst_left == 0) begin
            idle_cycles = $urandom_range(1, 20);
            s_valid <= 1'b0;
            repeat (idle_cycles) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        s_valid          <= 1'b1;
        s_source_address <= src;
        s_now_seconds    <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_verdicts.push_back(predict_verdict(src, now));
        if (burst_left > 0) burst_left--;
        @(negedge aclk);
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        @(negedge aclk);
        burst_left = 0;
    endtask

    task automatic check_limit_register(input logic reg_idx, input logic [15:0] want);
        logic [31:0] readback;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        readback = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[15:0] !== want)
            report_mismatch("register readback", 32'(want), 32'(readback[15:0]));
    endtask

    task automatic write_limit(input logic reg_idx, input logic [15:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (reg_idx == REG_MINUTE_LIMIT) minute_lim = value;
        else hour_lim = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        check_limit_register(reg_idx, value);
    endtask

    // limits read back at their reset values, then a lone source runs into the minute limit
    task automatic test_reset_limits();
        logic [31:0] src;
        logic [31:0] t;
        src = 32'h0A00_0001;
        t   = 32'h1000_0000;
        check_limit_register(REG_MINUTE_LIMIT, MINUTE_LIMIT_RST);
        check_limit_register(REG_HOUR_LIMIT, HOUR_LIMIT_RST);
        fast_mode = 1'b1;
        repeat (64) send_request(src, t);
        repeat (4) begin
            t = t + MINUTE_WINDOW;
            send_request(src, t);
        end
        wait_all_results();
        fast_mode = 1'b0;
    endtask

    task automatic test_window_rules();
        logic [31:0] a;
        logic [31:0] e;
        a = 32'h0000_0000;
        e = 32'hFFFF_FFFF;
        write_limit(REG_MINUTE_LIMIT, 16'd2);
        write_limit(REG_HOUR_LIMIT, 16'd3);
        send_request(a, 32'd0);
        send_request(a, 32'd10);
        send_request(a, 32'd70);
        send_request(a, 32'd3670);
        send_request(a, 32'd3671);
        send_request(a, 32'd3672);
        send_request(a, 32'd5);
        send_request(a, 32'd3604);
        send_request(a, 32'd7203);
        send_request(e, 32'hFFFF_FFFF);
        send_request(e, 32'h0000_003A);
        send_request(e, 32'h0000_0075);
        wait_all_results();
    endtask

    task automatic test_zero_limits();
        logic [31:0] b;
        b = 32'hC0A8_0001;
        write_limit(REG_MINUTE_LIMIT, 16'd0);
        write_limit(REG_HOUR_LIMIT, COUNT_MAX);
        send_request(32'h0000_0000, 32'd8000);
        send_request(b, 32'h8000_0000);
        send_request(b, 32'h8000_0E10);
        wait_all_results();
        write_limit(REG_MINUTE_LIMIT, COUNT_MAX);
        write_limit(REG_HOUR_LIMIT, 16'd0);
        send_request(b, 32'h8000_0E11);
        send_request(32'h0000_0000, 32'h7FFF_FFFF);
        wait_all_results();
    endtask

    task automatic test_table_full();
        logic [31:0] src;
        write_limit(REG_MINUTE_LIMIT, 16'd4);
        write_limit(REG_HOUR_LIMIT, 16'd20);
        while (stored_sources < TABLE_ENTRIES) begin
            src = $urandom;
            if (!source_stored(src)) send_request(src, $urandom);
        end
        src = $urandom;
        send_request(src, $urandom);
        send_request(src, $urandom);
        send_request(slot_source[TABLE_ENTRIES-1], slot_last[TABLE_ENTRIES-1] + 32'd1);
        wait_all_results();
    endtask

    // mostly stored sources with chosen gaps, some unknown sources on a full table
    task automatic test_random_traffic();
        int          slot;
        logic [31:0] src;
        logic [31:0] now;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_all_results();
            write_limit(REG_MINUTE_LIMIT, (phase == 0) ? 16'd1 :
                                          (phase == 1) ? COUNT_MAX : pick_limit());
            write_limit(REG_HOUR_LIMIT, (phase == 0) ? COUNT_MAX :
                                        (phase == 1) ? 16'd1 : pick_limit());
            repeat (PHASE_BEATS) begin
                if ($urandom_range(0, 7) == 0) begin
                    src = $urandom;
                    now = $urandom;
                end else begin
                    slot = $urandom_range(0, TABLE_ENTRIES - 1);
                    src  = slot_source[slot];
                    now  = slot_last[slot] + pick_gap();
                end
                send_request(src, now);
            end
        end
    endtask

    initial begin : ready_pattern
        ready_mode_t mode;
        int          mode_left;
        m_ready   = 1'b0;
        mode      = RDY_ALWAYS;
        mode_left = 0;
        forever begin
            @(negedge aclk);
            if (mode_left == 0) begin
                mode      = ready_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (fast_mode) begin
                m_ready <= 1'b1;
            end else begin
                case (mode)
                    RDY_ALWAYS: m_ready <= 1'b1;
                    RDY_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
                    default:    m_ready <= ($urandom_range(0, 11) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : result_check
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result beat with nothing expected, actual %0b 0x%08h %0b",
                             $time, m_blocked, m_next_allowed_at, m_table_full);
            end else begin
                want = pending_verdicts.pop_front();
                if (m_blocked !== want.blocked)
                    report_mismatch("blocked", 32'(want.blocked), 32'(m_blocked));
                if (m_next_allowed_at !== want.next_allowed_at)
                    report_mismatch("next_allowed_at", want.next_allowed_at, m_next_allowed_at);
                if (m_table_full !== want.table_full)
                    report_mismatch("table_full", 32'(want.table_full), 32'(m_table_full));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) quiet = 0;
            else quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        aresetn          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        s_valid          = 1'b0;
        s_source_address = '0;
        s_now_seconds    = '0;
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_limits();
        test_window_rules();
        test_zero_limits();
        test_table_full();
        test_random_traffic();
        wait_all_results();
        repeat (TABLE_ENTRIES + 8) @(posedge aclk);
        if (error_count == 0 && pending_verdicts.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
